// ----- rtl/core/tfp_pkg.sv -----
package tfp_pkg;

	localparam int StoreDepth = 14;
	localparam int IdxW = $clog2(StoreDepth);

	localparam logic [7:0] ChDollar = 8'h24;
	localparam logic [7:0] ChT      = 8'h54;
	localparam logic [7:0] ChG      = 8'h47;
	localparam logic [7:0] ChA      = 8'h41;
	localparam logic [7:0] ChS      = 8'h53;

	localparam logic [1:0] KindPos = 2'd0;
	localparam logic [1:0] KindAtt = 2'd1;
	localparam logic [1:0] KindSen = 2'd2;

	localparam logic [3:0] LenPos = 4'd14;
	localparam logic [3:0] LenAtt = 4'd6;
	localparam logic [3:0] LenSen = 4'd7;

	localparam logic [15:0] HeadingWrap = 16'd360;
	localparam logic [13:0] SpeedScale  = 14'd36;

	typedef struct packed {
		logic [1:0]         frame_kind;
		logic signed [31:0] latitude;
		logic signed [31:0] longitude;
		logic signed [31:0] altitude_cm;
		logic [13:0]        speed_tenth_kmh;
		logic [5:0]         sat_count;
		logic [1:0]         fix_type;
		logic signed [16:0] value_one;
		logic signed [16:0] value_two;
		logic signed [15:0] value_three;
		logic [7:0]         air_speed;
	} tfp_rec_t;

	function automatic logic [3:0] payload_len(input logic [1:0] kind);
		logic [3:0] len;
		case (kind)
			KindAtt: len = LenAtt;
			KindSen: len = LenSen;
			default: len = LenPos;
		endcase
		return len;
	endfunction

endpackage

// ----- rtl/core/tfp_in_reg.sv -----
module tfp_in_reg
	import tfp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,
	input  logic       out_ok,
	output logic       step,
	output logic [7:0] rx_byte
);

	logic       valid_s1;
	logic [7:0] byte_s1;

	assign step     = valid_s1 & out_ok;
	assign s_tready = ~valid_s1 | out_ok;
	assign rx_byte  = byte_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

endmodule

// ----- rtl/core/tfp_parse.sv -----
module tfp_parse
	import tfp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] rx_byte,
	output logic       fire,
	output tfp_rec_t   rec
);

	localparam logic [2:0] PhIdle    = 3'd0;
	localparam logic [2:0] PhDollar  = 3'd1;
	localparam logic [2:0] PhType    = 3'd2;
	localparam logic [2:0] PhPayload = 3'd3;

	logic [2:0]  phase_q;
	logic [1:0]  type_q;
	logic [3:0]  count_q;
	logic [7:0]  xor_q;
	logic [7:0]  store_q [StoreDepth];

	logic [2:0]  phase_d;
	logic [1:0]  type_d;
	logic [3:0]  count_d;
	logic [7:0]  xor_d;
	logic        wr_en;
	logic        frame_end;
	logic [7:0]  xor_next;
	logic [15:0] head;

	assign xor_next  = xor_q ^ rx_byte;
	assign frame_end = (phase_q == PhPayload) && (count_q >= payload_len(type_q));
	assign fire      = step && frame_end && (xor_next == 8'd0);

	always_comb begin
		phase_d = phase_q;
		type_d  = type_q;
		count_d = count_q;
		xor_d   = xor_q;
		wr_en   = 1'b0;
		case (phase_q)
			PhDollar: begin
				phase_d = (rx_byte == ChT) ? PhType : PhIdle;
			end
			PhType: begin
				phase_d = PhPayload;
				count_d = 4'd0;
				xor_d   = 8'd0;
				if (rx_byte == ChG) begin
					type_d = KindPos;
				end else if (rx_byte == ChA) begin
					type_d = KindAtt;
				end else if (rx_byte == ChS) begin
					type_d = KindSen;
				end else begin
					phase_d = PhIdle;
				end
			end
			PhPayload: begin
				xor_d = xor_next;
				if (frame_end) begin
					phase_d = PhIdle;
				end else begin
					wr_en   = 1'b1;
					count_d = count_q + 4'd1;
				end
			end
			default: begin
				phase_d = (rx_byte == ChDollar) ? PhDollar : PhIdle;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PhIdle;
			type_q  <= KindPos;
			count_q <= 4'd0;
			xor_q   <= 8'd0;
		end else if (step) begin
			phase_q <= phase_d;
			type_q  <= type_d;
			count_q <= count_d;
			xor_q   <= xor_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step && wr_en) begin
			store_q[count_q[IdxW-1:0]] <= rx_byte;
		end
	end

	assign head = {store_q[5], store_q[4]};

	always_comb begin
		rec = '0;
		rec.frame_kind = type_q;
		case (type_q)
			KindAtt: begin
				rec.value_one   = {store_q[1][7], store_q[1], store_q[0]};
				rec.value_two   = {store_q[3][7], store_q[3], store_q[2]};
				rec.value_three = head[15] ? head + HeadingWrap : head;
			end
			KindSen: begin
				rec.value_one   = {1'b0, store_q[1], store_q[0]};
				rec.value_two   = {1'b0, store_q[3], store_q[2]};
				rec.value_three = {8'd0, store_q[4]};
				rec.air_speed   = store_q[5];
			end
			default: begin
				rec.latitude        = {store_q[3], store_q[2], store_q[1], store_q[0]};
				rec.longitude       = {store_q[7], store_q[6], store_q[5], store_q[4]};
				rec.altitude_cm     = {store_q[12], store_q[11], store_q[10], store_q[9]};
				rec.speed_tenth_kmh = {6'd0, store_q[8]} * SpeedScale;
				rec.sat_count       = store_q[13][7:2];
				rec.fix_type        = store_q[13][1:0];
			end
		endcase
	end

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		fire |-> phase_q == PhPayload)
		else $error("Record issued outside the payload phase.");

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 4'(StoreDepth))
		else $error("Payload count ran past the store depth.");

	assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> phase_q == PhIdle)
		else $error("Parser did not return to idle after a record.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(step && phase_q == PhType) |=> (count_q == 4'd0 && xor_q == 8'd0))
		else $error("Frame start did not clear the count and check byte.");
`endif

endmodule

// ----- rtl/core/tfp_out_reg.sv -----
module tfp_out_reg
	import tfp_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     fire,
	input  tfp_rec_t rec,
	output logic     out_ok,
	output logic     m_tvalid,
	input  logic     m_tready,
	output tfp_rec_t rec_out
);

	logic     valid_q;
	tfp_rec_t rec_q;

	assign out_ok   = ~valid_q | m_tready;
	assign m_tvalid = valid_q;
	assign rec_out  = rec_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (fire) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rec_q <= rec;
		end
	end

endmodule

// ----- rtl/core/telemetry_frame_parser_core.sv -----
// Path: a check byte accepted into the input register raises fire, which loads its record
// into the record register and raises m_tvalid.
// Throughput: one byte per cycle; the input register and the record register both advance
// whenever the record register is empty or being taken.
// Reset: arst_n low clears the parser to idle and empties both registers at once;
// the payload store is not cleared.
module telemetry_frame_parser_core
	import tfp_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // [7:0] rx_byte
	output logic         m_tvalid,
	input  logic         m_tready,
	// [31:0] latitude, [63:32] longitude, [95:64] altitude_cm, [109:96] speed_tenth_kmh,
	// [115:110] sat_count, [117:116] fix_type, [134:118] value_one, [151:135] value_two,
	// [167:152] value_three, [175:168] air_speed
	output logic [175:0] m_tdata,
	output logic [1:0]   m_tuser    // [1:0] frame_kind
);

	logic       out_ok;
	logic       step;
	logic [7:0] rx_byte;
	logic       fire;
	tfp_rec_t   rec;
	tfp_rec_t   rec_out;

	tfp_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.out_ok   (out_ok),
		.step     (step),
		.rx_byte  (rx_byte)
	);

	tfp_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.rx_byte (rx_byte),
		.fire    (fire),
		.rec     (rec)
	);

	tfp_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.rec      (rec),
		.out_ok   (out_ok),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.rec_out  (rec_out)
	);

	assign m_tuser = rec_out.frame_kind;
	assign m_tdata = {rec_out.air_speed, rec_out.value_three, rec_out.value_two,
		rec_out.value_one, rec_out.fix_type, rec_out.sat_count, rec_out.speed_tenth_kmh,
		rec_out.altitude_cm, rec_out.longitude, rec_out.latitude};

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
	import tfp_pkg::*;

	typedef enum logic [2:0] {
		SeekDollar,
		SeekT,
		SeekType,
		InPayload
	} hunt_state_t;

	typedef logic [7:0] body_t [StoreDepth];

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [7:0]   s_tdata = 8'h00;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [175:0] m_tdata;
	logic [1:0]   m_tuser;

	logic [7:0]  byte_backlog[$];
	tfp_rec_t    pending_records[$];
	tfp_rec_t    oldest_record;
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	logic        word_taken = 1'b0;
	int          error_count = 0;
	int          words_accepted = 0;
	int          kind_count[4] = '{default: 0};

	hunt_state_t hunt = SeekDollar;
	logic [1:0]  cur_kind = KindPos;
	logic [3:0]  pay_count = 4'd0;
	logic [7:0]  check_acc = 8'h00;
	logic [7:0]  pay_buf[StoreDepth];

	telemetry_frame_parser_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	function automatic logic [15:0] le16(input int pos);
		return {pay_buf[pos + 1], pay_buf[pos]};
	endfunction

	function automatic logic [31:0] le32(input int pos);
		return {le16(pos + 2), le16(pos)};
	endfunction

	task automatic parse_rx_byte(input logic [7:0] c);
		tfp_rec_t          rec;
		logic signed [16:0] heading;
		logic [3:0]        body_len;
		case (hunt)
			SeekT: begin
				hunt = (c == ChT) ? SeekType : SeekDollar;
			end
			SeekType: begin
				hunt = InPayload;
				pay_count = 4'd0;
				check_acc = 8'h00;
				if (c == ChG) cur_kind = KindPos;
				else if (c == ChA) cur_kind = KindAtt;
				else if (c == ChS) cur_kind = KindSen;
				else hunt = SeekDollar;
			end
			InPayload: begin
				check_acc ^= c;
				case (cur_kind)
					KindAtt: body_len = LenAtt;
					KindSen: body_len = LenSen;
					default: body_len = LenPos;
				endcase
				if (pay_count >= body_len) begin
					hunt = SeekDollar;
					if (check_acc == 8'h00) begin
						rec = '0;
						rec.frame_kind = cur_kind;
						case (cur_kind)
							KindPos: begin
								rec.latitude = le32(0);
								rec.longitude = le32(4);
								rec.altitude_cm = le32(9);
								rec.speed_tenth_kmh = 14'(pay_buf[8]) * SpeedScale;
								rec.sat_count = pay_buf[13][7:2];
								rec.fix_type = pay_buf[13][1:0];
							end
							KindAtt: begin
								rec.value_one = 17'($signed(le16(0)));
								rec.value_two = 17'($signed(le16(2)));
								heading = 17'($signed(le16(4)));
								if (heading < 0)
									heading = heading + 17'(HeadingWrap);
								rec.value_three = heading[15:0];
							end
							default: begin
								rec.value_one = {1'b0, le16(0)};
								rec.value_two = {1'b0, le16(2)};
								rec.value_three = {8'h00, pay_buf[4]};
								rec.air_speed = pay_buf[5];
							end
						endcase
						pending_records.push_back(rec);
					end
				end else begin
					pay_buf[pay_count] = c;
					pay_count = pay_count + 4'd1;
				end
			end
			default: begin
				hunt = (c == ChDollar) ? SeekT : SeekDollar;
			end
		endcase
	endtask

	task automatic check_field(input string fname, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", fname, want, got);
			error_count++;
		end
	endtask

	function automatic logic [7:0] noisy_byte();
		logic [7:0] v;
		case ($urandom_range(0, 9))
			0: v = 8'h00;
			1: v = 8'hFF;
			2: v = 8'h80;
			3: v = 8'h7F;
			default: v = 8'($urandom);
		endcase
		return v;
	endfunction

	task automatic queue_frame(input logic [1:0] kind, input body_t body, input bit bad_check);
		logic [7:0] sum;
		int         n;
		sum = 8'h00;
		byte_backlog.push_back(ChDollar);
		byte_backlog.push_back(ChT);
		case (kind)
			KindAtt: begin
				n = int'(LenAtt);
				byte_backlog.push_back(ChA);
			end
			KindSen: begin
				n = int'(LenSen);
				byte_backlog.push_back(ChS);
			end
			default: begin
				n = int'(LenPos);
				byte_backlog.push_back(ChG);
			end
		endcase
		for (int i = 0; i < n; i++) begin
			byte_backlog.push_back(body[i]);
			sum ^= body[i];
		end
		if (bad_check)
			sum ^= 8'($urandom_range(1, 255));
		byte_backlog.push_back(sum);
	endtask

	// Mostly well-formed frames with random contents, the rest bad checks,
	// broken headers, truncated frames and line noise.
	task automatic queue_traffic(input int n_bytes);
		body_t body;
		int    pick;
		int    target;
		target = byte_backlog.size() + n_bytes;
		while (byte_backlog.size() < target) begin
			pick = $urandom_range(0, 99);
			foreach (body[i])
				body[i] = noisy_byte();
			if (pick < 85) begin
				queue_frame(2'($urandom_range(0, 2)), body, pick >= 75);
			end else if (pick < 93) begin
				byte_backlog.push_back(ChDollar);
				if ($urandom_range(0, 1) == 1)
					byte_backlog.push_back(ChT);
				repeat ($urandom_range(0, 5))
					byte_backlog.push_back(noisy_byte());
			end else begin
				repeat ($urandom_range(1, 4))
					byte_backlog.push_back(($urandom_range(0, 3) == 0) ? ChDollar : 8'($urandom));
			end
		end
	endtask

	task automatic wait_drained();
		while (byte_backlog.size() != 0 || s_tvalid || pending_records.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		forever #5 clk = ~clk;
	end

	always @(negedge clk) begin
		if (!s_tvalid || word_taken) begin
			if (byte_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				s_tvalid <= 1'b1;
				s_tdata <= byte_backlog.pop_front();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		word_taken <= s_tvalid && s_tready;
		if (arst_n && s_tvalid && s_tready) begin
			words_accepted++;
			parse_rx_byte(s_tdata);
		end
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_records.size() == 0) begin
				$error("Record word arrived with no record expected (kind %0d)", m_tuser);
				error_count++;
			end else begin
				oldest_record = pending_records.pop_front();
				kind_count[oldest_record.frame_kind]++;
				check_field("frame_kind", 32'(oldest_record.frame_kind), 32'(m_tuser));
				check_field("latitude", oldest_record.latitude, m_tdata[31:0]);
				check_field("longitude", oldest_record.longitude, m_tdata[63:32]);
				check_field("altitude_cm", oldest_record.altitude_cm, m_tdata[95:64]);
				check_field("speed_tenth_kmh", 32'(oldest_record.speed_tenth_kmh),
					32'(m_tdata[109:96]));
				check_field("sat_count", 32'(oldest_record.sat_count),
					32'(m_tdata[115:110]));
				check_field("fix_type", 32'(oldest_record.fix_type), 32'(m_tdata[117:116]));
				check_field("value_one", 32'($unsigned(oldest_record.value_one)),
					32'(m_tdata[134:118]));
				check_field("value_two", 32'($unsigned(oldest_record.value_two)),
					32'(m_tdata[151:135]));
				check_field("value_three", 32'($unsigned(oldest_record.value_three)),
					32'(m_tdata[167:152]));
				check_field("air_speed", 32'(oldest_record.air_speed),
					32'(m_tdata[175:168]));
			end
		end
	end

	initial begin
		body_t body;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_idle_pct = 28;
		recv_idle_pct = 49;

		// A lone T, a dollar followed by a second dollar, then an unknown type byte
		// that happens to be a dollar and must not restart the header hunt.
		byte_backlog.push_back(8'h00);
		byte_backlog.push_back(ChT);
		byte_backlog.push_back(ChDollar);
		byte_backlog.push_back(ChDollar);
		byte_backlog.push_back(ChT);
		byte_backlog.push_back(ChA);
		byte_backlog.push_back(ChDollar);
		byte_backlog.push_back(ChT);
		byte_backlog.push_back(ChDollar);
		byte_backlog.push_back(ChT);
		byte_backlog.push_back(ChG);

		foreach (body[i])
			body[i] = 8'hFF;
		queue_frame(KindPos, body, 1'b0);
		body[6] = 8'h00;
		queue_frame(KindSen, body, 1'b0);

		foreach (body[i])
			body[i] = 8'h00;
		queue_frame(KindPos, body, 1'b0);
		queue_frame(KindSen, body, 1'b0);
		body[3] = 8'h80;
		body[4] = 8'hFF;
		body[5] = 8'hFF;
		body[6] = 8'hFF;
		body[7] = 8'h7F;
		body[8] = 8'hFF;
		body[12] = 8'h80;
		body[13] = 8'hFC;
		queue_frame(KindPos, body, 1'b0);

		body[0] = 8'h00;
		body[1] = 8'h80;
		body[2] = 8'hFF;
		body[3] = 8'h7F;
		body[4] = 8'hFF;
		body[5] = 8'hFF;
		queue_frame(KindAtt, body, 1'b0);
		body[1] = 8'h00;
		body[3] = 8'hFF;
		body[4] = 8'h00;
		body[5] = 8'h80;
		queue_frame(KindAtt, body, 1'b0);
		body[4] = 8'hFF;
		body[5] = 8'h7F;
		queue_frame(KindAtt, body, 1'b0);
		queue_frame(KindAtt, body, 1'b1);

		queue_traffic(330);
		wait_drained();

		send_idle_pct = 49;
		recv_idle_pct = 28;
		queue_traffic(470);
		wait_drained();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		queue_traffic(470);
		wait_drained();

		repeat (16) @(posedge clk);
		$display("Fed %0d bytes of telemetry stream with header faults, bad checks and noise.",
			words_accepted);
		$display("Checked %0d position, %0d attitude and %0d sensor records.",
			kind_count[KindPos], kind_count[KindAtt], kind_count[KindSen]);
		if (error_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
